// File: sv/pcm_frame_downmixer_defines.svh
// assertion helpers used by the downmixer controller
// the using module provides clk_i and rst_ni
`ifndef PCM_FRAME_DOWNMIXER_DEFINES_SVH
`define PCM_FRAME_DOWNMIXER_DEFINES_SVH

// consequent checked in the same cycle
`define PFD_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// consequent checked in the next cycle
`define PFD_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

// File: sv/pfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

  // configuration register map
  localparam logic [1:0] CFG_BPS  = 2'd0;
  localparam logic [1:0] CFG_BIG  = 2'd1;
  localparam logic [1:0] CFG_KIND = 2'd2;
  localparam logic [1:0] CFG_CH   = 2'd3;

  // sample kinds
  localparam logic [1:0] KIND_SINT  = 2'd0;
  localparam logic [1:0] KIND_UINT  = 2'd1;
  localparam logic [1:0] KIND_FLOAT = 2'd2;
  localparam logic [1:0] KIND_ZERO  = 2'd3;

  typedef struct packed {
    logic take_byte;
    logic div_step;
    logic out_load;
  } pfd_cmd_t;

  typedef struct packed {
    logic frame_end;
  } pfd_status_t;

endpackage

`default_nettype wire

// File: sv/pfd_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_flag;

  modport source (output valid, output data_byte, output start_flag, input ready);
  modport sink   (input valid, input data_byte, input start_flag, output ready);
endinterface

`default_nettype wire

// File: sv/pfd_mono_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pfd_mono_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] mono_sample;

  modport source (output valid, output mono_sample, input ready);
  modport sink   (input valid, input mono_sample, output ready);
endinterface

`default_nettype wire

// File: sv/pcm_frame_downmixer.sv
// pcm frame downmixer: raw bytes in on the byte interface, one q1.23 mono sample per frame out
// within a frame a byte is taken every cycle that one is offered; the last byte of a frame starts a
// restoring divide by the channel count, one quotient bit a cycle, then a load into the
// output register, held while the previous sample is unsent
// result valid and input ready again together once the result is loaded
// async active-low reset clears frame progress and sets registers to 2, 0, 0, 1
`timescale 1ns / 1ps
`default_nettype none

module pcm_frame_downmixer #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [3:0] cfg_data_i,
  pfd_byte_if.sink        in_byte,
  pfd_mono_if.source      out_mono
);

  pfd_pkg::pfd_cmd_t    cmd;
  pfd_pkg::pfd_status_t status;
  logic                 in_ready;
  logic                 out_valid;
  logic signed [23:0]   mono_sample;

  pfd_controller #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_byte.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_mono.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfd_datapath #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .data_byte_i  (in_byte.data_byte),
    .start_flag_i (in_byte.start_flag),
    .cmd_i        (cmd),
    .status_o     (status),
    .mono_sample_o(mono_sample)
  );

  assign in_byte.ready        = in_ready;
  assign out_mono.valid       = out_valid;
  assign out_mono.mono_sample = mono_sample;

endmodule

`default_nettype wire

// File: sv/pfd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pfd_datapath #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [3:0]         cfg_data_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               start_flag_i,
  input  wire pfd_pkg::pfd_cmd_t  cmd_i,
  output pfd_pkg::pfd_status_t    status_o,
  output logic signed [23:0]      mono_sample_o
);

  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CMP_W = ((CH_W > 4) ? CH_W : 4) + 1;
  localparam int SUM_W = $clog2(MAX_CHANNELS) + 25;
  localparam int MAG_W = SUM_W - 1;

  localparam logic signed [24:0]      Q_ONE   = 25'sd8388608;
  localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] SAT_LO  = SUM_W'(-8388608);

  // channel sample to q1.23 in a 25-bit word
  function automatic logic signed [24:0] decode(input logic [31:0] w, input logic [2:0] bps,
                                                input logic [1:0] kind);
    logic        sg;
    logic [23:0] scaled;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [7:0]  sh;
    logic [23:0] mag;
    logic signed [24:0] res;
    sg = (kind == pfd_pkg::KIND_SINT);
    ex = w[30:23];
    man = w[22:0];
    sh = 8'd127 - ex;
    unique case (bps)
      3'd1:    scaled = {w[7] ^ sg, w[6:0], 16'h0000};
      3'd2:    scaled = {w[15] ^ sg, w[14:0], 8'h00};
      3'd3:    scaled = {w[23] ^ sg, w[22:0]};
      default: scaled = {w[31] ^ sg, w[30:8]};
    endcase
    if (ex >= 8'd127) begin
      mag = 24'h800000;
    end else if (ex == 8'd0 || sh >= 8'd24) begin
      mag = 24'h000000;
    end else begin
      mag = {1'b1, man} >> sh[4:0];
    end
    if (kind == pfd_pkg::KIND_FLOAT) begin
      if (bps != 3'd4) begin
        res = '0;
      end else if (ex == 8'hFF && man != 23'd0) begin
        res = Q_ONE;
      end else if (w[31]) begin
        res = -$signed({1'b0, mag});
      end else begin
        res = $signed({1'b0, mag});
      end
    end else if (kind == pfd_pkg::KIND_SINT || kind == pfd_pkg::KIND_UINT) begin
      res = $signed({1'b0, scaled}) - Q_ONE;
    end else begin
      res = '0;
    end
    return res;
  endfunction

  logic [2:0]              bps_q;
  logic                    big_q;
  logic [1:0]              kind_q;
  logic [3:0]              ch_q;
  logic [1:0]              pos_q, pos_d;
  logic [CI_W-1:0]         idx_q, idx_d;
  logic [31:0]             word_q, word_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;

  logic [CH_W-1:0]         rem_q, dvs_q;
  logic [MAG_W-1:0]        dvd_q;
  logic                    neg_q;
  logic signed [23:0]      mono_q;

  logic [2:0]              bps_eff;
  logic [CH_W-1:0]         ch_eff;
  logic [1:0]              pos_cur;
  logic [CI_W-1:0]         idx_cur;
  logic [31:0]             word_cur, word_new;
  logic signed [SUM_W-1:0] sum_cur, sum_new, sum_abs;
  logic signed [24:0]      chv;
  logic                    sample_end, frame_end;
  logic [CH_W:0]           rem_sh;
  logic                    qbit;
  logic signed [SUM_W-1:0] q_mag, q_signed;
  logic signed [23:0]      q_sat;

  always_comb begin
    if (bps_q == 3'd0) begin
      bps_eff = 3'd1;
    end else if (bps_q > 3'd4) begin
      bps_eff = 3'd4;
    end else begin
      bps_eff = bps_q;
    end
    if (ch_q == 4'd0) begin
      ch_eff = CH_W'(1);
    end else if (CMP_W'(ch_q) > CMP_W'(MAX_CHANNELS)) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = CH_W'(ch_q);
    end
  end

  // a start beat drops all frame progress before its byte lands
  always_comb begin
    pos_cur  = start_flag_i ? 2'd0 : pos_q;
    idx_cur  = start_flag_i ? '0 : idx_q;
    word_cur = start_flag_i ? 32'h0 : word_q;
    sum_cur  = start_flag_i ? '0 : sum_q;
    if (big_q) begin
      word_new = {word_cur[23:0], data_byte_i};
    end else begin
      word_new = word_cur | ({24'h000000, data_byte_i} << {pos_cur, 3'b000});
    end
    sample_end = ({1'b0, pos_cur} + 3'd1) >= bps_eff;
    frame_end  = sample_end && ((CMP_W'(idx_cur) + CMP_W'(1)) >= CMP_W'(ch_eff));
    chv        = decode(word_new, bps_eff, kind_q);
    sum_new    = sum_cur + SUM_W'(chv);
    sum_abs    = sum_new[SUM_W-1] ? -sum_new : sum_new;
  end

  assign status_o.frame_end = frame_end;

  always_comb begin
    pos_d  = pos_q;
    idx_d  = idx_q;
    word_d = word_q;
    sum_d  = sum_q;
    if (cmd_i.take_byte) begin
      priority if (frame_end) begin
        pos_d  = 2'd0;
        idx_d  = '0;
        word_d = 32'h0;
        sum_d  = '0;
      end else if (sample_end) begin
        pos_d  = 2'd0;
        idx_d  = CI_W'(idx_cur + CI_W'(1));
        word_d = 32'h0;
        sum_d  = sum_new;
      end else begin
        pos_d  = pos_cur + 2'd1;
        idx_d  = idx_cur;
        word_d = word_new;
        sum_d  = sum_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q  <= 3'd2;
      big_q  <= 1'b0;
      kind_q <= 2'd0;
      ch_q   <= 4'd1;
      pos_q  <= 2'd0;
      idx_q  <= '0;
      word_q <= 32'h0;
      sum_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pfd_pkg::CFG_BPS:  bps_q  <= cfg_data_i[2:0];
          pfd_pkg::CFG_BIG:  big_q  <= cfg_data_i[0];
          pfd_pkg::CFG_KIND: kind_q <= cfg_data_i[1:0];
          pfd_pkg::CFG_CH:   ch_q   <= cfg_data_i;
          default: ;
        endcase
      end
      pos_q  <= pos_d;
      idx_q  <= idx_d;
      word_q <= word_d;
      sum_q  <= sum_d;
    end
  end

  // restoring divide of the sum magnitude, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_q, dvd_q[MAG_W-1]};
    qbit   = rem_sh >= {1'b0, dvs_q};
  end

  always_comb begin
    q_mag    = $signed({1'b0, dvd_q});
    q_signed = neg_q ? -q_mag : q_mag;
    priority if (q_signed > SAT_HI) begin
      q_sat = SAT_HI[23:0];
    end else if (q_signed < SAT_LO) begin
      q_sat = SAT_LO[23:0];
    end else begin
      q_sat = q_signed[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && frame_end) begin
      neg_q <= sum_new[SUM_W-1];
      dvd_q <= sum_abs[MAG_W-1:0];
      rem_q <= '0;
      dvs_q <= ch_eff;
    end else if (cmd_i.div_step) begin
      rem_q <= qbit ? CH_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CH_W-1:0];
      dvd_q <= {dvd_q[MAG_W-2:0], qbit};
    end
    if (cmd_i.out_load) begin
      mono_q <= q_sat;
    end
  end

  assign mono_sample_o = mono_q;

endmodule

`default_nettype wire

// File: sv/pfd_controller.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pcm_frame_downmixer_defines.svh"

module pfd_controller #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire pfd_pkg::pfd_status_t status_i,
  output pfd_pkg::pfd_cmd_t         cmd_o
);

  localparam int MAG_W = $clog2(MAX_CHANNELS) + 24;
  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

  localparam logic [1:0] S_IN   = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             take;

  assign in_ready_o = (state_q == S_IN);
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.take_byte = take;
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IN: begin
        if (take && status_i.frame_end) begin
          state_d = S_DIV;
          cnt_d   = '0;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd_o.out_load) begin
          state_d = S_IN;
        end
      end
      default: state_d = S_IN;
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PFD_ASSERT_NEXT(a_frame_starts_div, take && status_i.frame_end, state_q == S_DIV && cnt_q == '0, "frame end did not start the divide")
  `PFD_ASSERT_SAME(a_cnt_range, state_q == S_DIV, cnt_q <= CNT_LAST, "divide counter out of range")
  `PFD_ASSERT_NEXT(a_div_done, state_q == S_DIV && cnt_q == CNT_LAST, state_q == S_DONE, "divide did not finish on its last step")
  `PFD_ASSERT_NEXT(a_load_valid, cmd_o.out_load, out_valid_q && state_q == S_IN, "loaded result not presented")

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int MIX_MAX_CH   = 8;
  localparam int Q_ONE        = 8388608;
  localparam int OUT_MAX      = 8388607;
  localparam int OUT_MIN      = -8388608;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 38;
  localparam int N_PHASES     = 13;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         idx;
    logic [3:0]         val;
    logic [7:0]         b;
    logic               s;
    bit                 typed;
    logic signed [23:0] want;
  } dir_row_t;

  typedef struct {
    logic [3:0] bps;
    logic [3:0] big;
    logic [3:0] kind;
    logic [3:0] ch;
  } setting_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [3:0] cfg_data;

  pfd_byte_if byte_if ();
  pfd_mono_if mono_if ();

  pcm_frame_downmixer #(
    .MAX_CHANNELS(MIX_MAX_CH)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_byte   (byte_if),
    .out_mono  (mono_if)
  );

  // mirror of the block's registers and frame progress
  logic [2:0]  r_bps;
  logic        r_big;
  logic [1:0]  r_kind;
  logic [3:0]  r_ch;
  int unsigned acc_pos;
  int unsigned acc_chan;
  logic [31:0] acc_word;
  int          acc_sum;

  logic signed [23:0] mono_due[$];
  logic signed [23:0] mon_want;
  dir_row_t           dir_tab[$];

  int  tx_pct;
  int  rx_pct;
  bit  hold_req;
  bit  hold_taken;
  int  n_bad;
  int  n_bytes;
  int  n_samples;
  int  n_settings;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("pcm_frame_downmixer verification failed");
    $finish;
  end

  function automatic int unsigned eff_bytes();
    if (r_bps == 3'd0) return 1;
    if (r_bps > 3'd4) return 4;
    return 32'(r_bps);
  endfunction

  function automatic int unsigned eff_chans();
    if (r_ch == 4'd0) return 1;
    if (r_ch > MIX_MAX_CH) return MIX_MAX_CH;
    return 32'(r_ch);
  endfunction

  // offset-binary word to q1.23 centered on zero
  function automatic int offset_to_q(logic [31:0] u, int unsigned bits);
    logic [31:0] scaled;
    scaled = (bits <= 24) ? (u << (24 - bits)) : (u >> (bits - 24));
    return int'(scaled) - Q_ONE;
  endfunction

  function automatic int float_to_q(logic [31:0] w);
    logic        neg;
    logic [7:0]  ex;
    logic [22:0] man;
    int          mag;
    int unsigned sh;
    neg = w[31];
    ex  = w[30:23];
    man = w[22:0];
    if (ex == 8'hFF && man != 23'd0) return Q_ONE;
    if (ex >= 8'd127) begin
      mag = Q_ONE;
    end else if (ex == 8'd0) begin
      mag = 0;
    end else begin
      sh  = 127 - ex;
      mag = (sh >= 24) ? 0 : int'({8'd0, 1'b1, man} >> sh);
    end
    return neg ? -mag : mag;
  endfunction

  function automatic int decode_sample(logic [31:0] w, int unsigned nb);
    int unsigned bits;
    logic [31:0] mask;
    logic [31:0] sgn;
    bits = nb * 8;
    mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
    sgn  = 32'd1 << (bits - 1);
    w    = w & mask;
    case (r_kind)
      pfd_pkg::KIND_SINT:  return offset_to_q(w ^ sgn, bits);
      pfd_pkg::KIND_UINT:  return offset_to_q(w, bits);
      pfd_pkg::KIND_FLOAT: return (nb == 4) ? float_to_q(w) : 0;
      default:             return 0;
    endcase
  endfunction

  // advances the frame state by one byte; returns 1 when a mono sample is due
  function automatic bit mix_byte(input logic [7:0] b, input logic s,
                                  output logic signed [23:0] res);
    int unsigned nb;
    int unsigned nc;
    int          avg;
    nb  = eff_bytes();
    nc  = eff_chans();
    res = '0;
    if (s) begin
      acc_pos  = 0;
      acc_chan = 0;
      acc_word = '0;
      acc_sum  = 0;
    end
    if (r_big) acc_word = {acc_word[23:0], b};
    else acc_word = acc_word | ({24'd0, b} << ((acc_pos % 4) * 8));
    acc_pos++;
    if (acc_pos < nb) return 1'b0;
    acc_sum += decode_sample(acc_word, nb);
    acc_pos  = 0;
    acc_word = '0;
    acc_chan++;
    if (acc_chan < nc) return 1'b0;
    avg = acc_sum / int'(nc);
    if (avg > OUT_MAX) avg = OUT_MAX;
    if (avg < OUT_MIN) avg = OUT_MIN;
    res      = avg[23:0];
    acc_chan = 0;
    acc_sum  = 0;
    return 1'b1;
  endfunction

  function automatic dir_row_t row_byte(logic [7:0] b, logic s);
    return '{1'b0, 2'd0, 4'd0, b, s, 1'b0, 24'sd0};
  endfunction

  function automatic dir_row_t row_want(logic [7:0] b, logic s, logic signed [23:0] v);
    return '{1'b0, 2'd0, 4'd0, b, s, 1'b1, v};
  endfunction

  function automatic dir_row_t row_cfg(logic [1:0] idx, logic [3:0] val);
    return '{1'b1, idx, val, 8'd0, 1'b0, 1'b0, 24'sd0};
  endfunction

  function automatic void add_row(dir_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic logic [31:0] pick_word(int unsigned nb);
    logic [31:0] top;
    logic        sg;
    top = 32'd1 << (nb * 8 - 1);
    sg  = 1'($urandom_range(1));
    if (r_kind == pfd_pkg::KIND_FLOAT && nb == 4) begin
      case ($urandom_range(11))
        0:       return 32'h3F80_0000;
        1:       return 32'hBF80_0000;
        2:       return 32'h7F80_0000;
        3:       return 32'hFF80_0000;
        4:       return {sg, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
        5:       return {sg, 31'd1};
        6:       return {sg, 31'h3F7F_FFFF};
        7:       return {sg, 31'h33FF_FFFF};
        8:       return {sg, 31'h3400_0000};
        9:       return {sg, 31'd0};
        default: return {sg, 8'($urandom_range(100, 126)), 23'($urandom)};
      endcase
    end
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return top;
      3:       return top - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s, input bit typed,
                           input logic signed [23:0] typed_val);
    logic signed [23:0] got;
    if ($urandom_range(99) < tx_pct) begin
      byte_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_pct);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= b;
    byte_if.start_flag <= s;
    do @(posedge clk_i); while (!byte_if.ready);
    n_bytes++;
    if (mix_byte(b, s, got)) mono_due.insert(mono_due.size(), typed ? typed_val : got);
  endtask

  // no more input until all samples are out and any divide has finished
  task automatic settle_idle();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (mono_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      pfd_pkg::CFG_BPS:  r_bps  = val[2:0];
      pfd_pkg::CFG_BIG:  r_big  = val[0];
      pfd_pkg::CFG_KIND: r_kind = val[1:0];
      pfd_pkg::CFG_CH:   r_ch   = val;
      default: ;
    endcase
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    mono_if.ready = 1'b0;
    forever begin
      if (hold_req && !hold_taken) begin
        mono_if.ready <= 1'b0;
        for (int hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk_i);
        hold_taken = 1'b1;
      end else begin
        mono_if.ready <= ($urandom_range(99) >= rx_pct);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && mono_if.valid && mono_if.ready) begin
      n_samples++;
      if (mono_due.size() == 0) begin
        if (n_bad < 10) $display("mismatch: unexpected mono beat %0d", mono_if.mono_sample);
        n_bad++;
      end else begin
        mon_want = mono_due.pop_front();
        if (mono_if.mono_sample !== mon_want) begin
          if (n_bad < 10) begin
            $display("mismatch: mono_sample expected %0d, got %0d", mon_want,
                     mono_if.mono_sample);
          end
          n_bad++;
        end
      end
    end
  end

  initial begin
    setting_t    ps;
    logic [31:0] w;
    int unsigned nb;
    int unsigned sh;
    int          ph_bytes;
    bit          resync;
    logic        s;

    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = '0;
    byte_if.start_flag = 1'b0;
    tx_pct             = 0;
    rx_pct             = 0;
    hold_req           = 1'b0;
    hold_taken         = 1'b0;
    n_bad              = 0;
    n_bytes            = 0;
    n_samples          = 0;
    n_settings         = 1;
    r_bps              = 3'd2;
    r_big              = 1'b0;
    r_kind             = pfd_pkg::KIND_SINT;
    r_ch               = 4'd1;
    acc_pos            = 0;
    acc_chan           = 0;
    acc_word           = '0;
    acc_sum            = 0;

    // reset defaults: 16-bit signed little-endian mono
    add_row(row_byte(8'h00, 1'b1));
    add_row(row_want(8'h80, 1'b0, -24'sd8388608));
    add_row(row_byte(8'hFF, 1'b0));
    add_row(row_want(8'h7F, 1'b0, 24'sd8388352));
    // start flag drops the stray half sample
    add_row(row_byte(8'h12, 1'b0));
    add_row(row_byte(8'h00, 1'b1));
    add_row(row_want(8'h00, 1'b0, 24'sd0));
    add_row(row_cfg(pfd_pkg::CFG_BPS, 4'd1));
    add_row(row_cfg(pfd_pkg::CFG_KIND, {2'b00, pfd_pkg::KIND_UINT}));
    add_row(row_want(8'hFF, 1'b0, 24'sd8323072));
    add_row(row_want(8'h00, 1'b0, -24'sd8388608));
    // float32 big-endian: +1 saturates, -1 exact, nan reads as +1
    add_row(row_cfg(pfd_pkg::CFG_BPS, 4'd4));
    add_row(row_cfg(pfd_pkg::CFG_BIG, 4'd1));
    add_row(row_cfg(pfd_pkg::CFG_KIND, {2'b00, pfd_pkg::KIND_FLOAT}));
    add_row(row_byte(8'h3F, 1'b1));
    add_row(row_byte(8'h80, 1'b0));
    add_row(row_byte(8'h00, 1'b0));
    add_row(row_want(8'h00, 1'b0, 24'sd8388607));
    add_row(row_byte(8'hBF, 1'b0));
    add_row(row_byte(8'h80, 1'b0));
    add_row(row_byte(8'h00, 1'b0));
    add_row(row_want(8'h00, 1'b0, -24'sd8388608));
    add_row(row_byte(8'h7F, 1'b0));
    add_row(row_byte(8'hC0, 1'b0));
    add_row(row_byte(8'h00, 1'b0));
    add_row(row_want(8'h01, 1'b0, 24'sd8388607));
    add_row(row_cfg(pfd_pkg::CFG_BPS, 4'd1));
    add_row(row_cfg(pfd_pkg::CFG_KIND, {2'b00, pfd_pkg::KIND_ZERO}));
    add_row(row_want(8'hFF, 1'b1, 24'sd0));
    // three-channel average, left to the predictor
    add_row(row_cfg(pfd_pkg::CFG_KIND, {2'b00, pfd_pkg::KIND_SINT}));
    add_row(row_cfg(pfd_pkg::CFG_BIG, 4'd0));
    add_row(row_cfg(pfd_pkg::CFG_CH, 4'd3));
    add_row(row_byte(8'h7F, 1'b1));
    add_row(row_byte(8'h7F, 1'b0));
    add_row(row_byte(8'h80, 1'b0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < dir_tab.size(); i++) begin
      if (dir_tab[i].is_cfg) begin
        if (i == 0 || !dir_tab[i - 1].is_cfg) begin
          settle_idle();
          n_settings++;
        end
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        if (i > 0 && dir_tab[i - 1].is_cfg) cfg_we <= 1'b0;
        send_byte(dir_tab[i].b, dir_tab[i].s, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: ps = '{4'd1, 4'd0, {2'b00, pfd_pkg::KIND_SINT}, 4'd1};
        1: ps = '{4'd4, 4'd1, {2'b00, pfd_pkg::KIND_FLOAT}, 4'd1};
        2: ps = '{4'd4, 4'd0, {2'b00, pfd_pkg::KIND_FLOAT}, 4'd2};
        3: ps = '{4'd2, 4'd1, {2'b00, pfd_pkg::KIND_UINT}, 4'd8};
        4: ps = '{4'd0, 4'd0, {2'b00, pfd_pkg::KIND_SINT}, 4'd0};
        5: ps = '{4'd15, 4'd15, {2'b11, pfd_pkg::KIND_SINT}, 4'd15};
        6: ps = '{4'd3, 4'd0, {2'b00, pfd_pkg::KIND_FLOAT}, 4'd3};
        7: ps = '{4'd1, 4'd1, {2'b00, pfd_pkg::KIND_ZERO}, 4'd4};
        8: ps = '{4'd3, 4'd1, {2'b00, pfd_pkg::KIND_SINT}, 4'd5};
        default: begin
          ps.bps  = {1'($urandom_range(1)), 3'($urandom_range(1, 4))};
          ps.big  = 4'($urandom);
          ps.kind = 4'($urandom);
          ps.ch   = ($urandom_range(9) == 0) ? 4'd8 : 4'($urandom_range(1, 4));
        end
      endcase
      settle_idle();
      write_reg(pfd_pkg::CFG_BPS, ps.bps);
      write_reg(pfd_pkg::CFG_BIG, ps.big);
      write_reg(pfd_pkg::CFG_KIND, ps.kind);
      write_reg(pfd_pkg::CFG_CH, ps.ch);
      cfg_we <= 1'b0;
      n_settings++;
      tx_pct = (ph % 4 == 1) ? 55 : (ph % 4 == 3) ? 36 : 0;
      rx_pct = (ph % 4 == 2) ? 55 : (ph % 4 == 3) ? 36 : 0;
      // long receiver hold-off so the block backs up into its input
      if (ph == 2) hold_req = 1'b1;

      ph_bytes = 0;
      resync   = ($urandom_range(9) < 7);
      while (ph_bytes < PHASE_BYTES) begin
        nb = eff_bytes();
        // broken sequence: stray bytes, then realign
        if ($urandom_range(99) < 4) begin
          repeat ($urandom_range(1, 3)) begin
            send_byte(8'($urandom), 1'($urandom_range(1)), 1'b0, 24'sd0);
            ph_bytes++;
          end
          resync = 1'b1;
        end
        if (ph == 3 && ph_bytes >= PHASE_BYTES / 2 && mono_due.size() != 0) begin
          byte_if.valid <= 1'b0;
          do @(posedge clk_i); while (mono_due.size() != 0);
        end
        w = pick_word(nb);
        for (int k = 0; k < nb; k++) begin
          sh = r_big ? nb - 1 - k : k;
          s  = (k == 0) && (resync || $urandom_range(99) < 3);
          send_byte(w[sh*8 +: 8], s, 1'b0, 24'sd0);
          ph_bytes++;
        end
        resync = 1'b0;
      end
    end

    byte_if.valid <= 1'b0;
    for (int wait_cnt = 0; wait_cnt < 60000 && mono_due.size() != 0; wait_cnt++) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mono_due.size() != 0) begin
      $display("%0d mono samples never arrived", mono_due.size());
      n_bad += mono_due.size();
    end

    $display("drove %0d pcm bytes across %0d register settings", n_bytes, n_settings);
    $display("checked %0d mono samples, %0d mismatches", n_samples, n_bad);
    if (n_bad == 0) begin
      $display("pcm_frame_downmixer verification clean");
    end else begin
      $display("pcm_frame_downmixer verification failed");
    end
    $finish;
  end

endmodule
